/* design/lbc_pkg.sv */
// Package for the LRU block buffer cache: sizes, command and result codes.
// No dependencies.
`default_nettype none
package lbc_pkg;
    localparam int SLOTS      = 16;
    localparam int BLOCK_BITS = 12;
    localparam int SW         = $clog2(SLOTS);
    localparam int CW         = 8;

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_VALID   = 2'd2;
    localparam logic [1:0] CMD_DIRTY   = 2'd3;

    localparam logic [1:0] KIND_DONE      = 2'd0;
    localparam logic [1:0] KIND_WRITEBACK = 2'd1;
    localparam logic [1:0] KIND_FULL      = 2'd2;
    localparam logic [1:0] KIND_UNDERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]            kind;
        logic [SW-1:0]         slot_index;
        logic [BLOCK_BITS-1:0] block_tag;
        logic                  was_hit;
        logic                  data_valid;
        logic                  last;
    } result_t;
endpackage
`default_nettype wire

/* design/lru_block_buffer_cache.sv */
// Top level of the LRU block buffer cache: slot metadata, a recency list and a
// sequencer that walks them one position a cycle unless the output stalls it.
//
// One command is taken at a time. A release or mark passes through the find
// and output states; a get walks the recency list with one shared compare
// step per position, then on a miss searches for a free clean slot from the
// least recent position, and failing that, writes back free dirty slots and
// searches again. Each result is a transfer through a single output
// register; the sequencer holds while it is full. A release that frees a
// slot also does the move-to-front search and shift, one position a cycle.
// No clearing pass after reset. Uses lbc_pkg.
`default_nettype none
module lru_block_buffer_cache (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_tvalid,
    output logic s_tready,
    // tdata: [1:0] command, [13:2] block_number, [17:14] slot, zero fill
    input  wire  [23:0] s_tdata,
    output logic m_tvalid,
    input  wire  m_tready,
    // tdata: [1:0] kind, [5:2] slot_index, [17:6] block_tag, [18] was_hit,
    //        [19] data_valid, zero fill
    output logic [23:0] m_tdata,
    output logic m_tlast
);
    localparam int SW = lbc_pkg::SW;
    localparam int BB = lbc_pkg::BLOCK_BITS;
    localparam int N  = lbc_pkg::SLOTS;
    localparam int PW = $clog2(N + 1);

    localparam logic [2:0] ST_IDLE = 3'd0, ST_HIT = 3'd1, ST_LRU = 3'd2,
        ST_WB = 3'd3, ST_MRU = 3'd4, ST_FIND = 3'd5, ST_SHIFT = 3'd6,
        ST_OUT = 3'd7;

    logic [BB-1:0] tag_reg [N];
    logic [N-1:0] present_reg, valid_reg, dirty_reg;
    logic [lbc_pkg::CW-1:0] cnt_reg [N];
    logic [SW-1:0] order_reg [N];

    logic [2:0] state_reg;
    logic [1:0] cmd_reg;
    logic [BB-1:0] blk_reg;
    logic [SW-1:0] slot_reg;
    logic [PW-1:0] pos_reg;
    logic any_reg;
    lbc_pkg::result_t res_reg, out_reg;
    logic out_full_reg;

    // shared step: slot at the current recency position
    logic [SW-1:0] cur;
    logic cur_free, cur_hit;
    assign cur = order_reg[pos_reg[SW-1:0]];
    assign cur_free = cnt_reg[cur] == '0;
    assign cur_hit = present_reg[cur] && tag_reg[cur] == blk_reg;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_full_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'd0, out_reg.data_valid, out_reg.was_hit, out_reg.block_tag,
                       out_reg.slot_index, out_reg.kind};

    logic out_free;
    assign out_free = !out_full_reg || m_tready;

    // load the output register with a write-back or a final result
    logic out_load;
    assign out_load = out_free && ((state_reg == ST_OUT)
        || (state_reg == ST_WB && cur_free && dirty_reg[cur]));

    function automatic lbc_pkg::result_t mk(input logic [1:0] k, input logic [SW-1:0] s,
            input logic [BB-1:0] t, input logic h, input logic v, input logic l);
        mk = '{kind: k, slot_index: s, block_tag: t, was_hit: h, data_valid: v, last: l};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_full_reg <= 1'b0;
            present_reg <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int i = 0; i < N; i++) begin
                cnt_reg[i] <= '0;
                order_reg[i] <= SW'(N - 1 - i);
            end
        end else begin
            if (out_load) out_full_reg <= 1'b1;
            else if (m_tready) out_full_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_tvalid) begin
                    cmd_reg <= s_tdata[1:0];
                    blk_reg <= s_tdata[2 +: BB];
                    slot_reg <= s_tdata[14 +: SW];
                    pos_reg <= '0;
                    any_reg <= 1'b0;
                    if (s_tdata[1:0] == lbc_pkg::CMD_GET) state_reg <= ST_HIT;
                    else state_reg <= ST_FIND;
                end
                ST_FIND: begin
                    // release / mark on slot_reg (slot field is SW bits, in range)
                    state_reg <= ST_OUT;
                    if (cmd_reg == lbc_pkg::CMD_RELEASE) begin
                        if (cnt_reg[slot_reg] == '0)
                            res_reg <= mk(lbc_pkg::KIND_UNDERFLOW, slot_reg,
                                present_reg[slot_reg] ? tag_reg[slot_reg] : '0, 1'b0,
                                valid_reg[slot_reg], 1'b1);
                        else begin
                            cnt_reg[slot_reg] <= cnt_reg[slot_reg] - 1'b1;
                            res_reg <= mk(lbc_pkg::KIND_DONE, slot_reg,
                                present_reg[slot_reg] ? tag_reg[slot_reg] : '0, 1'b0,
                                valid_reg[slot_reg], 1'b1);
                            if (cnt_reg[slot_reg] == lbc_pkg::CW'(1)) state_reg <= ST_SHIFT;
                        end
                    end else begin
                        if (cmd_reg == lbc_pkg::CMD_VALID) valid_reg[slot_reg] <= 1'b1;
                        else dirty_reg[slot_reg] <= 1'b1;
                        res_reg <= mk(lbc_pkg::KIND_DONE, slot_reg,
                            present_reg[slot_reg] ? tag_reg[slot_reg] : '0, 1'b0,
                            (cmd_reg == lbc_pkg::CMD_VALID) | valid_reg[slot_reg], 1'b1);
                    end
                end
                ST_SHIFT: begin
                    // find slot position, then shift down one step a cycle
                    if (!any_reg) begin
                        if (cur == slot_reg) any_reg <= 1'b1;
                        else pos_reg <= pos_reg + 1'b1;
                    end else if (pos_reg == '0) begin
                        order_reg[0] <= slot_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        order_reg[pos_reg[SW-1:0]] <= order_reg[pos_reg[SW-1:0] - 1'b1];
                        pos_reg <= pos_reg - 1'b1;
                    end
                end
                ST_HIT: begin
                    if (cur_hit) begin
                        if (cnt_reg[cur] != '1) cnt_reg[cur] <= cnt_reg[cur] + 1'b1;
                        res_reg <= mk(lbc_pkg::KIND_DONE, cur, blk_reg, 1'b1,
                            valid_reg[cur], 1'b1);
                        state_reg <= ST_OUT;
                    end else if (pos_reg == PW'(N - 1)) begin
                        state_reg <= ST_LRU;
                    end else pos_reg <= pos_reg + 1'b1;
                end
                ST_LRU: begin
                    // pos_reg walks down from the least recent position toward position 0
                    if (cur_free && !dirty_reg[cur]) begin
                        tag_reg[cur] <= blk_reg;
                        present_reg[cur] <= 1'b1;
                        valid_reg[cur] <= 1'b0;
                        cnt_reg[cur] <= lbc_pkg::CW'(1);
                        res_reg <= mk(lbc_pkg::KIND_DONE, cur, blk_reg, 1'b0, 1'b0, 1'b1);
                        state_reg <= ST_OUT;
                    end else if (pos_reg == '0) state_reg <= ST_WB;
                    else pos_reg <= pos_reg - 1'b1;
                end
                ST_WB: if (out_free) begin
                    if (cur_free && dirty_reg[cur]) begin
                        out_reg <= mk(lbc_pkg::KIND_WRITEBACK, cur,
                            present_reg[cur] ? tag_reg[cur] : '0, 1'b0, 1'b0, 1'b0);
                        valid_reg[cur] <= 1'b0;
                        dirty_reg[cur] <= 1'b0;
                        any_reg <= 1'b1;
                    end
                    if (pos_reg == PW'(N - 1)) begin
                        pos_reg <= '0;
                        if (any_reg || (cur_free && dirty_reg[cur])) state_reg <= ST_MRU;
                        else begin
                            res_reg <= mk(lbc_pkg::KIND_FULL, '0, '0, 1'b0, 1'b0, 1'b1);
                            state_reg <= ST_OUT;
                        end
                    end else pos_reg <= pos_reg + 1'b1;
                end
                ST_MRU: begin
                    if (cur_free && !dirty_reg[cur]) begin
                        tag_reg[cur] <= blk_reg;
                        present_reg[cur] <= 1'b1;
                        valid_reg[cur] <= 1'b0;
                        cnt_reg[cur] <= lbc_pkg::CW'(1);
                        res_reg <= mk(lbc_pkg::KIND_DONE, cur, blk_reg, 1'b0, 1'b0, 1'b1);
                        state_reg <= ST_OUT;
                    end else if (pos_reg == PW'(N - 1)) begin
                        res_reg <= mk(lbc_pkg::KIND_FULL, '0, '0, 1'b0, 1'b0, 1'b1);
                        state_reg <= ST_OUT;
                    end else pos_reg <= pos_reg + 1'b1;
                end
                ST_OUT: if (out_free) begin
                    out_reg <= res_reg;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            // a get's miss search starts at the least recent position
            if (state_reg == ST_HIT && !cur_hit && pos_reg == PW'(N - 1))
                pos_reg <= PW'(N - 1);
        end
    end
endmodule
`default_nettype wire
